// ----- hw/rtl/rbs_pkg.sv -----
// shared types and constants for the ray versus box slab test
package rbs_pkg;

    localparam int QBITS    = 33;   // quotient bits resolved by the divider chain
    localparam int N_AXES   = 3;
    localparam int LANES    = 6;    // near and far division per axis
    localparam int LATENCY  = 40;   // accept edge to result edge

    typedef logic signed [34:0] t_slab;

    // one division in flight through the cell chain
    typedef struct packed {
        logic [31:0]       rem;
        logic [QBITS-1:0]  num;
        logic [QBITS-1:0]  quo;
        logic              neg;
        logic              sat;
    } t_div_lane;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [30:0] entry;
        logic [2:0]  code;
    } t_res;

    // face codes
    localparam logic [2:0] NC_INSIDE = 3'd0;
    localparam logic [2:0] NC_NEG_X  = 3'd1;
    localparam logic [2:0] NC_POS_X  = 3'd2;
    localparam logic [2:0] NC_NEG_Y  = 3'd3;
    localparam logic [2:0] NC_POS_Y  = 3'd4;
    localparam logic [2:0] NC_NEG_Z  = 3'd5;
    localparam logic [2:0] NC_POS_Z  = 3'd6;

    localparam logic [2:0] FACE_MINUS [N_AXES] = '{NC_NEG_X, NC_NEG_Y, NC_NEG_Z};
    localparam logic [2:0] FACE_PLUS  [N_AXES] = '{NC_POS_X, NC_POS_Y, NC_POS_Z};

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z     = 3'd2;
    localparam logic [2:0] REG_DIR_X        = 3'd3;
    localparam logic [2:0] REG_DIR_Y        = 3'd4;
    localparam logic [2:0] REG_DIR_Z        = 3'd5;
    localparam logic [2:0] REG_MAX_DISTANCE = 3'd6;
    localparam logic [2:0] REG_BOX_PADDING  = 3'd7;

endpackage

// ----- hw/rtl/rbs_div_cell.sv -----
// one restoring division step, registered
module rbs_div_cell (
    input  logic                  i_clk,
    input  rbs_pkg::t_div_lane    i_lane,
    input  logic [31:0]           i_den,
    output rbs_pkg::t_div_lane    o_lane
);

    logic [32:0]        w_part;
    logic [32:0]        w_diff;
    logic               w_ge;
    rbs_pkg::t_div_lane n_lane;
    rbs_pkg::t_div_lane r_lane;

    always_comb begin
        w_part = {i_lane.rem, i_lane.num[rbs_pkg::QBITS-1]};
        w_diff = w_part - {1'b0, i_den};
        w_ge   = (w_part >= {1'b0, i_den});
        n_lane = i_lane;
        n_lane.rem = w_ge ? w_diff[31:0] : w_part[31:0];
        n_lane.num = {i_lane.num[rbs_pkg::QBITS-2:0], 1'b0};
        n_lane.quo = {i_lane.quo[rbs_pkg::QBITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

// ----- hw/rtl/rbs_slab_merge.sv -----
// orders slab parameters, merges axes and forms the result
module rbs_slab_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_kill,
    input  rbs_pkg::t_slab       i_t [rbs_pkg::LANES],
    input  logic [2:0]           i_skip,
    input  logic signed [31:0]   i_maxd,
    input  logic                 i_degen,
    output rbs_pkg::t_res        o_res
);

    rbs_pkg::t_slab r_near [rbs_pkg::N_AXES];
    rbs_pkg::t_slab r_far  [rbs_pkg::N_AXES];
    logic [2:0]     r_face [rbs_pkg::N_AXES];
    logic           r_vld1;
    logic           r_kill1;

    rbs_pkg::t_slab r_entry;
    rbs_pkg::t_slab r_exit;
    logic [2:0]     r_code;
    logic           r_vld2;
    logic           r_kill2;

    rbs_pkg::t_slab n_entry;
    rbs_pkg::t_slab n_exit;
    logic [2:0]     n_code;
    rbs_pkg::t_res  n_res;
    rbs_pkg::t_res  r_res;
    rbs_pkg::t_slab w_maxd;
    logic           w_hit;

    assign w_maxd = rbs_pkg::t_slab'(i_maxd);

    // order near and far per axis; equal values keep the minus face
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            if (i_t[2*a] > i_t[2*a+1]) begin
                r_near[a] <= i_t[2*a+1];
                r_far[a]  <= i_t[2*a];
                r_face[a] <= rbs_pkg::FACE_PLUS[a];
            end else begin
                r_near[a] <= i_t[2*a];
                r_far[a]  <= i_t[2*a+1];
                r_face[a] <= rbs_pkg::FACE_MINUS[a];
            end
        end
        r_kill1 <= i_kill;
    end

    // latest entry, earliest exit, first axis wins a tie
    always_comb begin
        n_entry = '0;
        n_exit  = w_maxd;
        n_code  = rbs_pkg::NC_INSIDE;
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            if (!i_skip[a]) begin
                if (r_near[a] > n_entry) begin
                    n_entry = r_near[a];
                    n_code  = r_face[a];
                end
                if (r_far[a] < n_exit) begin
                    n_exit = r_far[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_exit  <= n_exit;
        r_code  <= n_code;
        r_kill2 <= r_kill1;
    end

    always_comb begin
        w_hit = r_vld2 && !r_kill2 && !i_degen && (i_maxd > 32'sd0) &&
                (r_entry <= r_exit) && (r_entry <= w_maxd);
        n_res.done  = r_vld2;
        n_res.hit   = w_hit;
        n_res.entry = w_hit ? r_entry[30:0] : '0;
        n_res.code  = w_hit ? r_code : rbs_pkg::NC_INSIDE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_res  <= '0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/ray_box_slab_test.sv -----
// top level of the ray versus axis-aligned box slab test
// one ray is held in configuration registers and a stream of boxes is tested
// against it, one box per clock with no stall: busy stays low, so a box may
// be started in every cycle, and each box yields exactly one result, marked
// by o_done for a single cycle. the receiver cannot hold results off, so it
// must sample every o_done cycle. each box passes three input stages, the
// chain of 33 division cells (one quotient bit per cell, six lanes for the
// near and far slab of each axis), a post stage and three ordering and merge
// stages. configuration writes are taken in any cycle but must only be
// issued while no box is in flight.
module ray_box_slab_test #(
    parameter int FRAC_BITS   = 16,
    parameter int DIR_EPSILON = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // box channel
    input  logic               start,
    output logic               busy,
    input  logic               i_box_valid,
    input  logic signed [31:0] i_min_x,
    input  logic signed [31:0] i_min_y,
    input  logic signed [31:0] i_min_z,
    input  logic signed [31:0] i_max_x,
    input  logic signed [31:0] i_max_y,
    input  logic signed [31:0] i_max_z,
    // result channel
    output logic               o_done,
    output logic               o_hit,
    output logic [30:0]        o_entry_distance,
    output logic [2:0]         o_normal_code,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int NW    = 34 + FRAC_BITS;         // scaled numerator magnitude
    localparam int CELLS = rbs_pkg::QBITS;
    localparam int DEPTH = CELLS + 4;              // s0, s1, s2, cells, post

    // ray registers
    logic signed [31:0] r_origin [rbs_pkg::N_AXES];
    logic signed [31:0] r_dir    [rbs_pkg::N_AXES];
    logic signed [31:0] r_max_distance;
    logic [30:0]        r_box_padding;

    // values derived from the ray, registered behind the ray registers
    logic [31:0]        r_den    [rbs_pkg::N_AXES];
    logic [2:0]         r_nz;
    logic [63:0]        r_sq     [rbs_pkg::N_AXES];
    logic               r_degen;
    logic [31:0]        w_abs    [rbs_pkg::N_AXES];
    logic [63:0]        w_lensq;

    // control chain
    logic [DEPTH-1:0]   r_vld;
    logic [DEPTH-1:0]   r_kill;
    logic               w_accept;
    logic               w_rej;

    // datapath stages
    logic signed [31:0] w_min    [rbs_pkg::N_AXES];
    logic signed [31:0] w_max    [rbs_pkg::N_AXES];
    logic signed [33:0] r_lo     [rbs_pkg::N_AXES];
    logic signed [33:0] r_hi     [rbs_pkg::N_AXES];
    logic signed [34:0] w_dlo    [rbs_pkg::N_AXES];
    logic signed [34:0] w_dhi    [rbs_pkg::N_AXES];
    logic signed [34:0] r_diff   [rbs_pkg::LANES];
    logic [34:0]        w_mag    [rbs_pkg::LANES];
    logic [NW-1:0]      w_num    [rbs_pkg::LANES];
    rbs_pkg::t_div_lane n_s2     [rbs_pkg::LANES];
    rbs_pkg::t_div_lane r_s2     [rbs_pkg::LANES];
    rbs_pkg::t_div_lane w_chain  [rbs_pkg::LANES][CELLS+1];
    logic [33:0]        w_qmag   [rbs_pkg::LANES];
    rbs_pkg::t_slab     r_t      [rbs_pkg::LANES];
    rbs_pkg::t_res      w_res;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin[0]    <= '0;
            r_origin[1]    <= '0;
            r_origin[2]    <= '0;
            r_dir[0]       <= 32'sd65536;
            r_dir[1]       <= '0;
            r_dir[2]       <= '0;
            r_max_distance <= 32'sh7fff_ffff;
            r_box_padding  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rbs_pkg::REG_ORIGIN_X:     r_origin[0]    <= i_cfg_data;
                rbs_pkg::REG_ORIGIN_Y:     r_origin[1]    <= i_cfg_data;
                rbs_pkg::REG_ORIGIN_Z:     r_origin[2]    <= i_cfg_data;
                rbs_pkg::REG_DIR_X:        r_dir[0]       <= i_cfg_data;
                rbs_pkg::REG_DIR_Y:        r_dir[1]       <= i_cfg_data;
                rbs_pkg::REG_DIR_Z:        r_dir[2]       <= i_cfg_data;
                rbs_pkg::REG_MAX_DISTANCE: r_max_distance <= i_cfg_data;
                rbs_pkg::REG_BOX_PADDING:  r_box_padding  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // direction magnitude, near-zero axes and degenerate ray; squares wrap
    // modulo 2^64 in their sum
    always_comb begin
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            w_abs[a] = r_dir[a][31] ? 32'(-r_dir[a]) : 32'(r_dir[a]);
        end
        w_lensq = r_sq[0] + r_sq[1] + r_sq[2];
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            r_den[a] <= w_abs[a];
            r_nz[a]  <= (w_abs[a] <= 32'(DIR_EPSILON));
            r_sq[a]  <= 64'(r_dir[a]) * 64'(r_dir[a]);
        end
        r_degen <= (w_lensq <= (64'(DIR_EPSILON) << FRAC_BITS));
    end

    // stage 0: pad the box
    assign w_min[0] = i_min_x;
    assign w_min[1] = i_min_y;
    assign w_min[2] = i_min_z;
    assign w_max[0] = i_max_x;
    assign w_max[1] = i_max_y;
    assign w_max[2] = i_max_z;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            r_lo[a] <= 34'(w_min[a]) - 34'($signed({1'b0, r_box_padding}));
            r_hi[a] <= 34'(w_max[a]) + 34'($signed({1'b0, r_box_padding}));
        end
    end

    // stage 1: offsets from the origin; a near-zero axis with the origin
    // outside its slab rejects the box
    always_comb begin
        w_rej = 1'b0;
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            w_dlo[a] = 35'(r_lo[a]) - 35'(r_origin[a]);
            w_dhi[a] = 35'(r_hi[a]) - 35'(r_origin[a]);
            if (r_nz[a] && ((w_dlo[a] > 35'sd0) || (w_dhi[a] < 35'sd0))) begin
                w_rej = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < rbs_pkg::N_AXES; a++) begin
            r_diff[2*a]   <= w_dlo[a];
            r_diff[2*a+1] <= w_dhi[a];
        end
    end

    // stage 2: sign and magnitude, quotients of 2^33 and up saturate
    always_comb begin
        for (int l = 0; l < rbs_pkg::LANES; l++) begin
            w_mag[l] = r_diff[l][34] ? 35'(-r_diff[l]) : 35'(r_diff[l]);
            w_num[l] = {w_mag[l][33:0], {FRAC_BITS{1'b0}}};
            n_s2[l].rem = 32'(w_num[l][NW-1:CELLS]);
            n_s2[l].num = w_num[l][CELLS-1:0];
            n_s2[l].quo = '0;
            n_s2[l].neg = r_diff[l][34] ^ r_dir[l/2][31];
            n_s2[l].sat = (32'(w_num[l][NW-1:CELLS]) >= r_den[l/2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < rbs_pkg::LANES; l++) begin
            r_s2[l] <= n_s2[l];
        end
    end

    // divider chain, one quotient bit per cell
    for (genvar l = 0; l < rbs_pkg::LANES; l++) begin : g_lane
        assign w_chain[l][0] = r_s2[l];
        for (genvar c = 0; c < CELLS; c++) begin : g_cell
            rbs_div_cell u_cell (
                .i_clk  (i_clk),
                .i_lane (w_chain[l][c]),
                .i_den  (r_den[l/2]),
                .o_lane (w_chain[l][c+1])
            );
        end
    end

    // post stage: signed slab parameter, truncated toward zero
    always_comb begin
        for (int l = 0; l < rbs_pkg::LANES; l++) begin
            w_qmag[l] = w_chain[l][CELLS].sat ? (34'd1 << CELLS)
                                              : {1'b0, w_chain[l][CELLS].quo};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < rbs_pkg::LANES; l++) begin
            r_t[l] <= w_chain[l][CELLS].neg ? -$signed({1'b0, w_qmag[l]})
                                            :  $signed({1'b0, w_qmag[l]});
        end
    end

    // item valid and miss flags travel beside the datapath
    always_ff @(posedge i_clk) begin
        r_kill <= {r_kill[DEPTH-2:1], r_kill[0] | w_rej, !i_box_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], w_accept};
        end
    end

    rbs_slab_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[DEPTH-1]),
        .i_kill  (r_kill[DEPTH-1]),
        .i_t     (r_t),
        .i_skip  (r_nz),
        .i_maxd  (r_max_distance),
        .i_degen (r_degen),
        .o_res   (w_res)
    );

    assign o_done           = w_res.done;
    assign o_hit            = w_res.hit;
    assign o_entry_distance = w_res.entry;
    assign o_normal_code    = w_res.code;

endmodule

// ----- hw/rtl/rbs_checker.sv -----
// port level checks for the slab test, bound to the top level
module rbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_box_valid,
    input logic               o_done,
    input logic               o_hit,
    input logic [30:0]        o_entry_distance,
    input logic [2:0]         o_normal_code
);

    // a hit is only reported with a result
    a_hit_has_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_done)
        else $error("hit without result strobe");

    // a miss carries zero fields
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_entry_distance == 31'd0 &&
                                o_normal_code == rbs_pkg::NC_INSIDE))
        else $error("miss with nonzero fields");

    // an invalid box never hits
    a_invalid_miss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_box_valid) |-> ##40 !o_hit)
        else $error("invalid box reported a hit");

    // reset flushes results
    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result after reset");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (.*);

// ----- test/tb_ray_box_slab_test.sv -----
// testbench for the ray versus box slab test: directed and random boxes checked against a predictor
module tb_ray_box_slab_test;
    timeunit 1ns;
    timeprecision 1ps;

    // box item as driven on the ports
    typedef struct {
        logic        valid;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
    } t_box;

    // one expected answer
    typedef struct {
        logic        hit;
        logic [30:0] entry;
        logic [2:0]  code;
    } t_answer;

    localparam int  EPS       = 1;
    localparam int  FRAC      = 16;
    localparam int  WD_LIMIT  = 20000;
    localparam int  N_RANDOM  = 1250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_box_valid = 1'b0;
    logic signed [31:0] i_min_x = '0, i_min_y = '0, i_min_z = '0;
    logic signed [31:0] i_max_x = '0, i_max_y = '0, i_max_z = '0;
    logic        o_done;
    logic        o_hit;
    logic [30:0] o_entry_distance;
    logic [2:0]  o_normal_code;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    ray_box_slab_test dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the ray registers
    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    logic signed [31:0] ray_maxd;
    logic [30:0]        ray_pad;

    t_box    pending_boxes [$];
    t_answer expected_answers [$];
    int      errors = 0;
    int      quiet_cycles = 0;
    bit      quiet_mode = 1'b0;   // long stretch without sender gaps
    bit      hold_off = 1'b0;     // sender paused by the stimulus process

    // slab test on one box, in 64-bit exact arithmetic
    function automatic t_answer slab_answer(t_box b);
        t_answer r;
        longint lo, hi, org, dir, t0, t1, tmp, entry, exitd, lensq;
        logic [2:0] face, code;
        r = '{1'b0, '0, '0};
        entry = 0;
        exitd = ray_maxd;
        lensq = 0;
        code = rbs_pkg::NC_INSIDE;
        for (int a = 0; a < 3; a++)
            lensq += longint'(ray_dir[a]) * longint'(ray_dir[a]);
        if (!b.valid || ray_maxd <= 0 || lensq <= (longint'(EPS) << FRAC))
            return r;
        for (int a = 0; a < 3; a++) begin
            org = ray_org[a];
            dir = ray_dir[a];
            lo = longint'($signed(b.lo[a])) - longint'(ray_pad);
            hi = longint'($signed(b.hi[a])) + longint'(ray_pad);
            if ((dir < 0 ? -dir : dir) <= EPS) begin
                if (org < lo || org > hi)
                    return r;
                continue;
            end
            // division truncates toward zero
            t0 = ((lo - org) * (longint'(1) << FRAC)) / dir;
            t1 = ((hi - org) * (longint'(1) << FRAC)) / dir;
            face = rbs_pkg::FACE_MINUS[a];
            if (t0 > t1) begin
                tmp = t0; t0 = t1; t1 = tmp;
                face = rbs_pkg::FACE_PLUS[a];
            end
            if (t0 > entry) begin
                entry = t0;
                code = face;
            end
            if (t1 < exitd)
                exitd = t1;
            if (entry > exitd)
                return r;
        end
        if (entry > longint'(ray_maxd))
            return r;
        if (entry > 64'h7fff_ffff)
            entry = 64'h7fff_ffff;
        r.hit = 1'b1;
        r.entry = entry[30:0];
        r.code = code;
        return r;
    endfunction

    // driver: one box per accepted start, random gaps, fields from the queue head
    always @(posedge i_clk) begin
        t_box nb;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_answers.push_back(slab_answer(pending_boxes.pop_front()));
            end
            if (pending_boxes.size() > 0 && !hold_off
                && (quiet_mode || $urandom_range(99) >= 12)) begin
                nb = pending_boxes[0];
                start       <= 1'b1;
                i_box_valid <= nb.valid;
                i_min_x <= nb.lo[0]; i_min_y <= nb.lo[1]; i_min_z <= nb.lo[2];
                i_max_x <= nb.hi[0]; i_max_y <= nb.hi[1]; i_max_z <= nb.hi[2];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every o_done cycle carries a result
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_done) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit=%0b entry=%0h code=%0d",
                         $time, o_hit, o_entry_distance, o_normal_code);
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (o_hit !== e.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, e.hit, o_hit);
                    errors++;
                end
                if (o_entry_distance !== e.entry) begin
                    $display("%0t: entry expected %0h actual %0h", $time, e.entry,
                             o_entry_distance);
                    errors++;
                end
                if (o_normal_code !== e.code) begin
                    $display("%0t: code expected %0d actual %0d", $time, e.code,
                             o_normal_code);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // wait until queued boxes are taken and every answer is back, plus drain time
    task automatic drain();
        wait (pending_boxes.size() == 0 && start == 1'b0);
        wait (expected_answers.size() == 0);
        repeat (rbs_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    // write one ray register while idle; mirror into the predictor
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx) inside
            rbs_pkg::REG_ORIGIN_X, rbs_pkg::REG_ORIGIN_Y, rbs_pkg::REG_ORIGIN_Z:
                ray_org[idx[1:0]] = val;
            rbs_pkg::REG_DIR_X, rbs_pkg::REG_DIR_Y, rbs_pkg::REG_DIR_Z:
                ray_dir[2'(idx - rbs_pkg::REG_DIR_X)] = val;
            rbs_pkg::REG_MAX_DISTANCE:
                ray_maxd = val;
            default:
                ray_pad = val[30:0];
        endcase
    endtask

    // small coordinate in Q16.16, mostly within +-64 units
    function automatic logic [31:0] coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(8388608)) - 4194304);
        endcase
    endfunction

    function automatic logic [31:0] dir_val();
        case ($urandom_range(9))
            0:       return $urandom_range(2) - 1;     // near zero axis
            1:       return $urandom;
            default: return 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    task automatic add_box(int v, logic [31:0] a0, a1, a2, b0, b1, b2);
        t_box b;
        b.valid = (v != 0);
        b.lo[0] = a0; b.lo[1] = a1; b.lo[2] = a2;
        b.hi[0] = b0; b.hi[1] = b1; b.hi[2] = b2;
        pending_boxes.push_back(b);
    endtask

    // box around a random centre most of the time, so entries and faces vary
    task automatic add_random_box();
        logic [31:0] c [3], h [3];
        for (int a = 0; a < 3; a++) begin
            c[a] = coord();
            h[a] = $urandom_range(3) == 0 ? $urandom : $urandom_range(1048576);
        end
        if ($urandom_range(9) == 0)
            add_box(int'($urandom_range(1)), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        else
            add_box(int'($urandom_range(15) != 0),
                    c[0] - h[0], c[1] - h[1], c[2] - h[2],
                    c[0] + h[0], c[1] + h[1], c[2] + h[2]);
    endtask

    task automatic random_ray();
        write_reg(rbs_pkg::REG_ORIGIN_X, coord());
        write_reg(rbs_pkg::REG_ORIGIN_Y, coord());
        write_reg(rbs_pkg::REG_ORIGIN_Z, coord());
        write_reg(rbs_pkg::REG_DIR_X, dir_val());
        write_reg(rbs_pkg::REG_DIR_Y, dir_val());
        write_reg(rbs_pkg::REG_DIR_Z, dir_val());
        case ($urandom_range(7))
            0:       write_reg(rbs_pkg::REG_MAX_DISTANCE,
                               $urandom_range(1) ? 32'd0 : $urandom);
            1:       write_reg(rbs_pkg::REG_MAX_DISTANCE, 32'h7fff_ffff);
            default: write_reg(rbs_pkg::REG_MAX_DISTANCE, $urandom_range(33554432, 1));
        endcase
        case ($urandom_range(5))
            0:       write_reg(rbs_pkg::REG_BOX_PADDING,
                               $urandom_range(1) ? 32'h7fff_ffff : $urandom);
            1, 2:    write_reg(rbs_pkg::REG_BOX_PADDING, 32'd0);
            default: write_reg(rbs_pkg::REG_BOX_PADDING, $urandom_range(65536));
        endcase
    endtask

    initial begin
        // predictor starts from the reset values of the ray
        ray_org = '{0, 0, 0};
        ray_dir = '{65536, 0, 0};
        ray_maxd = 32'h7fff_ffff;
        ray_pad = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset ray along +x
        add_box(1, 32'h0002_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0004_0000, 32'h0001_0000, 32'h0001_0000);          // entry 2.0, -x face
        add_box(1, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);          // origin inside
        add_box(0, 32'h0002_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0004_0000, 32'h0001_0000, 32'h0001_0000);          // invalid box
        add_box(1, 32'h0002_0000, 32'h0002_0000, 32'hffff_0000,
                32'h0004_0000, 32'h0003_0000, 32'h0001_0000);          // near zero axis outside
        add_box(1, 32'h0004_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0002_0000, 32'h0001_0000, 32'h0001_0000);          // inverted box
        add_box(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);          // extreme corners
        add_box(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_box(1, 32'hfffc_0000, 32'hffff_0000, 32'hffff_0000,
                32'hfffe_0000, 32'h0001_0000, 32'h0001_0000);          // box behind the ray
        drain();

        // negative diagonal ray: plus faces, equal slab parameters
        write_reg(rbs_pkg::REG_DIR_X, 32'hffff_0000);
        write_reg(rbs_pkg::REG_DIR_Y, 32'hffff_0000);
        write_reg(rbs_pkg::REG_DIR_Z, 32'hffff_0000);
        write_reg(rbs_pkg::REG_ORIGIN_Y, 32'h0000_8000);
        add_box(1, 32'hfffb_0000, 32'hfffb_0000, 32'hfffb_0000,
                32'hfffd_0000, 32'hfffd_0000, 32'hfffd_0000);
        add_box(1, 32'hfffb_0000, 32'hfffc_0000, 32'hfffa_0000,
                32'hfffd_0000, 32'hfffc_0000, 32'hfffe_0000);          // flat y slab
        add_box(1, 32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000,
                32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000);          // point box
        drain();
        // degenerate ray, then non-positive distance, then full padding
        write_reg(rbs_pkg::REG_DIR_X, 32'd1);
        write_reg(rbs_pkg::REG_DIR_Y, 32'hffff_ffff);
        write_reg(rbs_pkg::REG_DIR_Z, 32'd0);
        add_box(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();
        write_reg(rbs_pkg::REG_DIR_X, 32'h7fff_ffff);
        write_reg(rbs_pkg::REG_MAX_DISTANCE, 32'h8000_0000);
        add_box(1, 32'h0001_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        drain();
        write_reg(rbs_pkg::REG_MAX_DISTANCE, 32'd1);
        write_reg(rbs_pkg::REG_BOX_PADDING, 32'h7fff_ffff);
        add_box(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_box(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        drain();

        // random phases, each with a fresh ray; one phase has no gaps
        for (int ph = 0; ph < 25; ph++) begin
            random_ray();
            quiet_mode = (ph == 5);
            for (int n = 0; n < N_RANDOM / 25; n++) begin
                add_random_box();
                // once mid phase, hold the sender until all answers are in
                if (ph == 10 && n == 20) begin
                    wait (pending_boxes.size() == 0 && start == 1'b0);
                    hold_off = 1'b1;
                    wait (expected_answers.size() == 0);
                    hold_off = 1'b0;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
